// ----- hw/rtl/obse_pkg.sv -----
package obse_pkg;

  localparam logic [1:0] UPD_ADD    = 2'd0;
  localparam logic [1:0] UPD_MODIFY = 2'd1;
  localparam logic [1:0] UPD_CANCEL = 2'd2;
  localparam logic [1:0] UPD_OTHER  = 2'd3;

  localparam logic [2:0] MSG_START  = 3'd0;
  localparam logic [2:0] MSG_CLEAR  = 3'd1;
  localparam logic [2:0] MSG_ORDER  = 3'd2;
  localparam logic [2:0] MSG_END    = 3'd3;
  localparam logic [2:0] MSG_STATUS = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP_ADD  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_SEQ_GAP  = 3'd4;

  // One queued command, already classified by the front end.
  typedef struct packed {
    logic               publish;
    logic               in_range;
    logic [31:0]        seq;
    logic [1:0]         utype;
    logic [1:0]         ticker;
    logic [2:0]         slot;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        prio;
  } cmd_t;

  typedef struct packed {
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        prio;
  } entry_t;

  typedef struct packed {
    logic [5:0]         snap_seq;
    logic [2:0]         msg_type;
    logic [1:0]         ticker;
    logic [31:0]        order_id;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        prio;
    logic [2:0]         status;
    logic               last;
  } msg_t;

endpackage

// ----- hw/rtl/obse_front.sv -----
module obse_front import obse_pkg::*; #(
  parameter int TICKERS           = 4,
  parameter int ORDERS_PER_TICKER = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [31:0]        seq_num_i,
  input  logic [1:0]         update_type_i,
  input  logic [1:0]         ticker_i,
  input  logic [2:0]         order_index_i,
  input  logic               side_i,
  input  logic signed [31:0] price_i,
  input  logic [31:0]        quantity_i,
  input  logic [31:0]        priority_req_i,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               q_full_i
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign push_o     = vld_q && !q_full_i;
  assign in_ready_o = !vld_q || push_o;
  assign take       = in_valid_i && in_ready_o;
  assign vld_d      = take || (vld_q && !push_o);
  assign cmd_o      = cmd_q;

  always_comb begin
    cmd_d         = cmd_q;
    if (take) begin
      cmd_d.publish  = kind_i;
      cmd_d.in_range = (32'(ticker_i) < 32'(TICKERS)) &&
                       (32'(order_index_i) < 32'(ORDERS_PER_TICKER));
      cmd_d.seq     = seq_num_i;
      cmd_d.utype   = update_type_i;
      cmd_d.ticker  = ticker_i;
      cmd_d.slot    = order_index_i;
      cmd_d.side    = side_i;
      cmd_d.price   = price_i;
      cmd_d.qty     = quantity_i;
      cmd_d.prio    = priority_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ----- hw/rtl/obse_fifo.sv -----
module obse_fifo import obse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/obse_back.sv -----
module obse_back import obse_pkg::*; #(
  parameter int TICKERS           = 4,
  parameter int ORDERS_PER_TICKER = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output msg_t msg_o
);

  localparam int SLOTS = TICKERS * ORDERS_PER_TICKER;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW    = (TICKERS > 1) ? $clog2(TICKERS) : 1;
  localparam int SW    = (ORDERS_PER_TICKER > 1) ? $clog2(ORDERS_PER_TICKER) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_END   = 3'd6;

  logic [2:0]       state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [IW-1:0]    upd_idx_q, upd_idx_d;
  logic [IW-1:0]    pidx_q, pidx_d;
  logic [TW-1:0]    t_q, t_d;
  logic [SW-1:0]    s_q, s_d;
  logic [5:0]       n_q, n_d;
  logic [31:0]      last_seq_q, last_seq_d;
  logic [SLOTS-1:0] valid_q, valid_d;
  logic             out_valid_q, out_valid_d;
  msg_t             out_q, out_d;

  entry_t           mem_q [SLOTS];
  entry_t           rdata_q;
  entry_t           wdata;
  logic             we;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    head_idx;

  logic             out_free;
  logic             load;
  logic [2:0]       status;
  logic             entry_live;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign msg_o       = out_q;

  assign head_idx = cmd_i.in_range ?
                    IW'(IW'(cmd_i.ticker) * IW'(ORDERS_PER_TICKER) + IW'(cmd_i.slot)) :
                    '0;

  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_addr = head_idx;
      S_UPD:   rd_addr = upd_idx_q;
      default: rd_addr = pidx_q;
    endcase
  end

  // Table check for an update; a table fault outranks a sequence gap.
  always_comb begin
    entry_live = cmd_q.in_range && valid_q[upd_idx_q];
    status     = ST_OK;
    if (cmd_q.utype != UPD_OTHER) begin
      priority if (!cmd_q.in_range) begin
        status = ST_UNKNOWN;
      end else if (cmd_q.utype == UPD_ADD) begin
        if (entry_live) begin
          status = ST_DUP_ADD;
        end
      end else if (!entry_live) begin
        status = ST_UNKNOWN;
      end else if (rdata_q.side != cmd_q.side) begin
        status = ST_MISMATCH;
      end
    end
    if (status == ST_OK && cmd_q.seq != last_seq_q + 32'd1) begin
      status = ST_SEQ_GAP;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    upd_idx_d  = upd_idx_q;
    pidx_d     = pidx_q;
    t_d        = t_q;
    s_d        = s_q;
    n_d        = n_q;
    last_seq_d = last_seq_q;
    valid_d    = valid_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    out_d      = '0;
    we         = 1'b0;
    wdata      = rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o     = 1'b1;
          cmd_d     = cmd_i;
          upd_idx_d = head_idx;
          pidx_d    = '0;
          t_d       = '0;
          s_d       = '0;
          n_d       = '0;
          state_d   = cmd_i.publish ? S_START : S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          load         = 1'b1;
          out_d.msg_type = MSG_STATUS;
          out_d.status = status;
          out_d.last   = 1'b1;
          last_seq_d   = cmd_q.seq;
          if (status == ST_OK) begin
            unique case (cmd_q.utype)
              UPD_ADD: begin
                we                 = 1'b1;
                wdata.side         = cmd_q.side;
                wdata.price        = cmd_q.price;
                wdata.qty          = cmd_q.qty;
                wdata.prio         = cmd_q.prio;
                valid_d[upd_idx_q] = 1'b1;
              end
              UPD_MODIFY: begin
                we          = 1'b1;
                wdata.price = cmd_q.price;
                wdata.qty   = cmd_q.qty;
              end
              UPD_CANCEL: valid_d[upd_idx_q] = 1'b0;
              default: ;
            endcase
          end
          state_d = S_IDLE;
        end
      end
      S_START: begin
        if (out_free) begin
          load           = 1'b1;
          out_d.snap_seq = n_q;
          out_d.msg_type = MSG_START;
          out_d.order_id = last_seq_q;
          n_d            = n_q + 6'd1;
          state_d        = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (out_free) begin
          load           = 1'b1;
          out_d.snap_seq = n_q;
          out_d.msg_type = MSG_CLEAR;
          out_d.ticker   = 2'(t_q);
          n_d            = n_q + 6'd1;
          state_d        = S_RD;
        end
      end
      S_RD, S_ORD: begin
        if (state_q == S_RD && valid_q[pidx_q]) begin
          // Slot is live: its stored fields arrive from the table next cycle.
          state_d = S_ORD;
        end else if (state_q == S_RD || out_free) begin
          if (state_q == S_ORD) begin
            load           = 1'b1;
            out_d.snap_seq = n_q;
            out_d.msg_type = MSG_ORDER;
            out_d.ticker   = 2'(t_q);
            out_d.order_id = 32'(s_q);
            out_d.side     = rdata_q.side;
            out_d.price    = rdata_q.price;
            out_d.qty      = rdata_q.qty;
            out_d.prio     = rdata_q.prio;
            n_d            = n_q + 6'd1;
          end
          pidx_d = pidx_q + IW'(1);
          if (s_q == SW'(ORDERS_PER_TICKER - 1)) begin
            s_d = '0;
            if (t_q == TW'(TICKERS - 1)) begin
              state_d = S_END;
            end else begin
              t_d     = t_q + TW'(1);
              state_d = S_CLEAR;
            end
          end else begin
            s_d     = s_q + SW'(1);
            state_d = S_RD;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          load           = 1'b1;
          out_d.snap_seq = n_q;
          out_d.msg_type = MSG_END;
          out_d.order_id = last_seq_q;
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_seq_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      pidx_q      <= '0;
      t_q         <= '0;
      s_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      last_seq_q  <= last_seq_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      pidx_q      <= pidx_d;
      t_q         <= t_d;
      s_q         <= s_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    upd_idx_q <= upd_idx_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[upd_idx_q] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

// ----- hw/rtl/order_book_snapshot_engine.sv -----
// Order book snapshot engine. Market updates (add, modify, cancel) maintain a table of
// TICKERS x ORDERS_PER_TICKER live orders and each returns one status transaction; a
// publish request returns a start marker, a clear marker per ticker followed by that
// ticker's live orders in slot order, and an end marker with last set. Items pass an
// input register and a two-entry queue, so the input keeps accepting, until both are full,
// while the back end works or the output is stalled. The back end handles one item at a
// time: an update pops the queue with a table read, then checks and writes back once the
// output is free; a publish walks the single-port order table one slot per cycle, with an
// extra step per live order to present its stored fields, and waits whenever a message
// meets a stalled output. The order table needs no clearing pass after reset.
module order_book_snapshot_engine import obse_pkg::*; #(
  parameter int TICKERS           = 4,
  parameter int ORDERS_PER_TICKER = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [31:0]        seq_num_i,
  input  logic [1:0]         update_type_i,
  input  logic [1:0]         ticker_i,
  input  logic [2:0]         order_index_i,
  input  logic               side_i,
  input  logic signed [31:0] price_i,
  input  logic [31:0]        quantity_i,
  input  logic [31:0]        priority_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         snapshot_seq_o,
  output logic [2:0]         msg_type_o,
  output logic [1:0]         out_ticker_o,
  output logic [31:0]        out_order_id_o,
  output logic               out_side_o,
  output logic signed [31:0] out_price_o,
  output logic [31:0]        out_quantity_o,
  output logic [31:0]        out_priority_o,
  output logic [2:0]         status_o,
  output logic               last_o
);

  logic push, q_full, q_valid, pop;
  cmd_t front_cmd, head_cmd;
  msg_t msg;

  obse_front #(
    .TICKERS          (TICKERS),
    .ORDERS_PER_TICKER(ORDERS_PER_TICKER)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .seq_num_i     (seq_num_i),
    .update_type_i (update_type_i),
    .ticker_i      (ticker_i),
    .order_index_i (order_index_i),
    .side_i        (side_i),
    .price_i       (price_i),
    .quantity_i    (quantity_i),
    .priority_req_i(priority_req_i),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .q_full_i      (q_full)
  );

  obse_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (head_cmd)
  );

  obse_back #(
    .TICKERS          (TICKERS),
    .ORDERS_PER_TICKER(ORDERS_PER_TICKER)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .msg_o      (msg)
  );

  assign snapshot_seq_o = msg.snap_seq;
  assign msg_type_o     = msg.msg_type;
  assign out_ticker_o   = msg.ticker;
  assign out_order_id_o = msg.order_id;
  assign out_side_o     = msg.side;
  assign out_price_o    = msg.price;
  assign out_quantity_o = msg.qty;
  assign out_priority_o = msg.prio;
  assign status_o       = msg.status;
  assign last_o         = msg.last;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import obse_pkg::*;

  localparam int TICKERS     = 4;
  localparam int ORDERS      = 8;
  localparam int SLOTS       = TICKERS * ORDERS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 80;

  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_PUBLISH = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        seq;
    logic [1:0]         utype;
    logic [1:0]         ticker;
    logic [2:0]         slot;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        qty;
    logic [31:0]        prio;
  } book_req_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_LONG} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic [31:0]        seq_num_i = '0;
  logic [1:0]         update_type_i = '0;
  logic [1:0]         ticker_i = '0;
  logic [2:0]         order_index_i = '0;
  logic               side_i = 1'b0;
  logic signed [31:0] price_i = '0;
  logic [31:0]        quantity_i = '0;
  logic [31:0]        priority_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [5:0]         snapshot_seq_o;
  logic [2:0]         msg_type_o;
  logic [1:0]         out_ticker_o;
  logic [31:0]        out_order_id_o;
  logic               out_side_o;
  logic signed [31:0] out_price_o;
  logic [31:0]        out_quantity_o;
  logic [31:0]        out_priority_o;
  logic [2:0]         status_o;
  logic               last_o;

  order_book_snapshot_engine #(
    .TICKERS          (TICKERS),
    .ORDERS_PER_TICKER(ORDERS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .seq_num_i     (seq_num_i),
    .update_type_i (update_type_i),
    .ticker_i      (ticker_i),
    .order_index_i (order_index_i),
    .side_i        (side_i),
    .price_i       (price_i),
    .quantity_i    (quantity_i),
    .priority_req_i(priority_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .snapshot_seq_o(snapshot_seq_o),
    .msg_type_o    (msg_type_o),
    .out_ticker_o  (out_ticker_o),
    .out_order_id_o(out_order_id_o),
    .out_side_o    (out_side_o),
    .out_price_o   (out_price_o),
    .out_quantity_o(out_quantity_o),
    .out_priority_o(out_priority_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // Shadow copy of the order table and the feed position.
  logic        book_live [SLOTS];
  entry_t      book_entry [SLOTS];
  logic [31:0] seq_last;

  msg_t pending_msgs [$];
  int   err_count = 0;
  int   cycle_cnt = 0;

  int  burst_left = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_free = 1'b0;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_phase = 0;
  int       rx_hold = 0;
  int       rx_tick = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic msg_t mk_msg(input logic [5:0] n, input logic [2:0] mtype,
                                  input logic [1:0] tick, input logic [31:0] id,
                                  input entry_t ent, input logic [2:0] code,
                                  input logic fin);
    msg_t m;
    m.snap_seq = n;
    m.msg_type = mtype;
    m.ticker   = tick;
    m.order_id = id;
    m.side     = ent.side;
    m.price    = ent.price;
    m.qty      = ent.qty;
    m.prio     = ent.prio;
    m.status   = code;
    m.last     = fin;
    return m;
  endfunction

  // Applies one accepted transaction to the shadow table and queues the
  // messages the engine owes for it.
  task automatic book_apply(input book_req_t req);
    logic [5:0] n;
    logic [2:0] code;
    int         idx;
    bit         in_book;
    entry_t     blank;
    blank = '0;
    if (req.kind == KIND_PUBLISH) begin
      n = '0;
      pending_msgs.push_back(mk_msg(n, MSG_START, '0, seq_last, blank, ST_OK, 1'b0));
      n++;
      for (int t = 0; t < TICKERS; t++) begin
        pending_msgs.push_back(mk_msg(n, MSG_CLEAR, t[1:0], '0, blank, ST_OK, 1'b0));
        n++;
        for (int s = 0; s < ORDERS; s++) begin
          if (book_live[t * ORDERS + s]) begin
            pending_msgs.push_back(mk_msg(n, MSG_ORDER, t[1:0], s,
                                          book_entry[t * ORDERS + s], ST_OK, 1'b0));
            n++;
          end
        end
      end
      pending_msgs.push_back(mk_msg(n, MSG_END, '0, seq_last, blank, ST_OK, 1'b1));
    end else begin
      in_book = (req.ticker < TICKERS) && (req.slot < ORDERS);
      idx = in_book ? req.ticker * ORDERS + req.slot : 0;
      code = ST_OK;
      if (req.utype != UPD_OTHER) begin
        if (!in_book) begin
          code = ST_UNKNOWN;
        end else if (req.utype == UPD_ADD) begin
          if (book_live[idx]) code = ST_DUP_ADD;
        end else if (!book_live[idx]) begin
          code = ST_UNKNOWN;
        end else if (book_entry[idx].side != req.side) begin
          code = ST_MISMATCH;
        end
      end
      if (code == ST_OK && req.seq != seq_last + 32'd1) code = ST_SEQ_GAP;
      if (code == ST_OK) begin
        case (req.utype)
          UPD_ADD: begin
            book_live[idx]       = 1'b1;
            book_entry[idx].side = req.side;
            book_entry[idx].price = req.price;
            book_entry[idx].qty  = req.qty;
            book_entry[idx].prio = req.prio;
          end
          UPD_MODIFY: begin
            book_entry[idx].price = req.price;
            book_entry[idx].qty   = req.qty;
          end
          UPD_CANCEL: begin
            book_live[idx] = 1'b0;
          end
          default: begin
          end
        endcase
      end
      seq_last = req.seq;
      pending_msgs.push_back(mk_msg('0, MSG_STATUS, '0, '0, blank, code, 1'b1));
    end
  endtask

  task automatic note_error(input string what);
    err_count++;
    if (err_count <= 10) $display("ERROR at cycle %0d: %s", cycle_cnt, what);
  endtask

  always @(posedge clk_i) begin : result_check
    msg_t got;
    msg_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.snap_seq = snapshot_seq_o;
      got.msg_type = msg_type_o;
      got.ticker   = out_ticker_o;
      got.order_id = out_order_id_o;
      got.side     = out_side_o;
      got.price    = out_price_o;
      got.qty      = out_quantity_o;
      got.prio     = out_priority_o;
      got.status   = status_o;
      got.last     = last_o;
      if (pending_msgs.size() == 0) begin
        note_error($sformatf("unexpected transaction type=%0d seq=%0d", got.msg_type,
                             got.snap_seq));
      end else begin
        want = pending_msgs.pop_front();
        if (got.snap_seq !== want.snap_seq || got.msg_type !== want.msg_type ||
            got.ticker !== want.ticker || got.order_id !== want.order_id ||
            got.side !== want.side || got.price !== want.price ||
            got.qty !== want.qty || got.prio !== want.prio ||
            got.status !== want.status || got.last !== want.last) begin
          note_error($sformatf(
            "exp seq=%0d type=%0d tick=%0d id=%h side=%b px=%h qty=%h pr=%h st=%0d last=%b",
            want.snap_seq, want.msg_type, want.ticker, want.order_id, want.side,
            want.price, want.qty, want.prio, want.status, want.last));
          if (err_count <= 10)
            $display(
              "  got seq=%0d type=%0d tick=%0d id=%h side=%b px=%h qty=%h pr=%h st=%0d last=%b",
              got.snap_seq, got.msg_type, got.ticker, got.order_id, got.side,
              got.price, got.qty, got.prio, got.status, got.last);
        end
      end
    end
  end

  // Receiver back-pressure: the pattern is redrawn at random intervals.
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_phase == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_phase = $urandom_range(20, 80);
    end else begin
      rx_phase--;
    end
    if (rx_free) begin
      out_ready_i = 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready_i = 1'b1;
        RX_COIN:    out_ready_i = 1'($urandom_range(0, 1));
        RX_QUARTER: out_ready_i = (rx_tick % 4 == 0);
        default: begin
          if (rx_hold == 0) begin
            out_ready_i = 1'b1;
            rx_hold     = $urandom_range(0, 7);
          end else begin
            out_ready_i = 1'b0;
            rx_hold--;
          end
        end
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input book_req_t req);
    int gap;
    if (tx_idle_en && burst_left == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    kind_i         = req.kind;
    seq_num_i      = req.seq;
    update_type_i  = req.utype;
    ticker_i       = req.ticker;
    order_index_i  = req.slot;
    side_i         = req.side;
    price_i        = req.price;
    quantity_i     = req.qty;
    priority_req_i = req.prio;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    book_apply(req);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  function automatic book_req_t mk_upd(input logic [31:0] seq, input logic [1:0] utype,
                                       input int tick, input int slot, input logic side,
                                       input logic [31:0] price, input logic [31:0] qty,
                                       input logic [31:0] prio);
    book_req_t r;
    r.kind   = KIND_UPDATE;
    r.seq    = seq;
    r.utype  = utype;
    r.ticker = 2'(tick);
    r.slot   = 3'(slot);
    r.side   = side;
    r.price  = price;
    r.qty    = qty;
    r.prio   = prio;
    return r;
  endfunction

  // A publish request carries random junk in the update fields.
  function automatic book_req_t mk_pub();
    book_req_t r;
    r = mk_upd($urandom, 2'($urandom_range(0, 3)), $urandom_range(0, 3),
               $urandom_range(0, 7), 1'($urandom_range(0, 1)), $urandom, $urandom,
               $urandom);
    r.kind = KIND_PUBLISH;
    return r;
  endfunction

  function automatic bit find_slot(input logic want_live, output int idx);
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (start + k) % SLOTS;
      if (book_live[idx] == want_live) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_random_item();
    book_req_t r;
    int        pick;
    int        idx;
    r = mk_upd(seq_last + 32'd1, UPD_OTHER, $urandom_range(0, 3), $urandom_range(0, 7),
               1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r = mk_pub();
    end else if (pick < 38) begin
      r.utype = UPD_ADD;
      if (find_slot(1'b0, idx)) begin
        r.ticker = 2'(idx / ORDERS);
        r.slot   = 3'(idx % ORDERS);
      end
    end else if (pick < 58 || (pick < 76 && pick >= 58)) begin
      r.utype = (pick < 58) ? UPD_MODIFY : UPD_CANCEL;
      if (find_slot(1'b1, idx)) begin
        r.ticker = 2'(idx / ORDERS);
        r.slot   = 3'(idx % ORDERS);
        r.side   = book_entry[idx].side;
      end
    end else if (pick < 82) begin
      r.utype = UPD_OTHER;
    end else if (pick < 91) begin
      // Random target: duplicates, unknown orders and side mismatches.
      r.utype = 2'($urandom_range(0, 2));
    end else begin
      r.utype = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       r.seq = $urandom;
        1:       r.seq = seq_last;
        default: r.seq = seq_last + $urandom_range(2, 1000);
      endcase
    end
    send_item(r);
  endtask

  task automatic run_directed();
    send_item(mk_pub());
    send_item(mk_upd(32'd1, UPD_ADD, 0, 0, 1'b0, 32'h8000_0000, 32'd0, 32'd0));
    send_item(mk_upd(32'd2, UPD_ADD, 3, 7, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF));
    send_item(mk_upd(32'd3, UPD_ADD, 0, 0, 1'b0, 32'd5, 32'd5, 32'd5));
    send_item(mk_upd(32'd4, UPD_MODIFY, 0, 0, 1'b1, 32'd9, 32'd9, 32'd9));
    // Modify keeps the stored priority.
    send_item(mk_upd(32'd5, UPD_MODIFY, 0, 0, 1'b0, 32'd12345, 32'd77, 32'hDEAD_BEEF));
    send_item(mk_upd(32'd6, UPD_MODIFY, 1, 2, 1'b0, 32'd1, 32'd1, 32'd1));
    send_item(mk_upd(32'd7, UPD_CANCEL, 2, 4, 1'b1, 32'd0, 32'd0, 32'd0));
    send_item(mk_upd(32'd8, UPD_CANCEL, 3, 7, 1'b0, 32'd0, 32'd0, 32'd0));
    send_item(mk_upd(32'd9, UPD_OTHER, 1, 1, 1'b1, $urandom, $urandom, $urandom));
    // A gap leaves the table alone but still moves the sequence number.
    send_item(mk_upd(32'd20, UPD_ADD, 1, 3, 1'b1, 32'hFFFF_FFFF, 32'd3, 32'd4));
    send_item(mk_upd(32'd21, UPD_ADD, 1, 3, 1'b1, 32'hFFFF_FFFF, 32'd3, 32'd4));
    // Table faults win over a sequence gap.
    send_item(mk_upd(32'd30, UPD_ADD, 0, 0, 1'b0, 32'd0, 32'd0, 32'd0));
    send_item(mk_upd(32'd40, UPD_OTHER, 2, 2, 1'b0, 32'd0, 32'd0, 32'd0));
    send_item(mk_pub());
    send_item(mk_upd(32'hFFFF_FFFF, UPD_OTHER, 0, 0, 1'b0, 32'd0, 32'd0, 32'd0));
    // The sequence number wraps from all ones to zero.
    send_item(mk_upd(32'd0, UPD_ADD, 2, 5, 1'b1, 32'hFFFF_FF00, 32'd100, 32'd7));
    send_item(mk_upd(32'd1, UPD_CANCEL, 3, 7, 1'b1, 32'd0, 32'd0, 32'd0));
    send_item(mk_pub());
    send_item(mk_upd(32'd2, UPD_CANCEL, 0, 0, 1'b0, 32'd0, 32'd0, 32'd0));
    send_item(mk_upd(32'd3, UPD_CANCEL, 1, 3, 1'b1, 32'd0, 32'd0, 32'd0));
    send_item(mk_upd(32'd4, UPD_CANCEL, 2, 5, 1'b1, 32'd0, 32'd0, 32'd0));
    send_item(mk_pub());
  endtask

  // Fills every slot, publishes the longest snapshot, then empties the table and publishes.
  task automatic run_full_book();
    for (int i = 0; i < SLOTS; i++) begin
      if (!book_live[i])
        send_item(mk_upd(seq_last + 32'd1, UPD_ADD, i / ORDERS, i % ORDERS,
                         1'($urandom_range(0, 1)), $urandom, $urandom, $urandom));
    end
    send_item(mk_pub());
    for (int i = 0; i < SLOTS; i++) begin
      send_item(mk_upd(seq_last + 32'd1, UPD_CANCEL, i / ORDERS, i % ORDERS,
                       book_entry[i].side, $urandom, $urandom, $urandom));
    end
    send_item(mk_pub());
  endtask

  task automatic run_random_feed(input int count);
    for (int i = 0; i < count; i++) send_random_item();
    send_item(mk_pub());
  endtask

  task automatic run_back_to_back(input int count);
    tx_idle_en = 1'b0;
    rx_free    = 1'b1;
    for (int i = 0; i < count; i++) send_random_item();
    send_item(mk_pub());
    tx_idle_en = 1'b1;
    rx_free    = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      book_live[i]  = 1'b0;
      book_entry[i] = '0;
    end
    seq_last = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    run_full_book();
    run_random_feed(160);
    run_back_to_back(30);

    in_valid_i = 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/obse_pkg.sv
hw/rtl/obse_front.sv
hw/rtl/obse_fifo.sv
hw/rtl/obse_back.sv
hw/rtl/order_book_snapshot_engine.sv
dv/tb_top.sv
